// ===== src/q2e_pkg.sv =====
// q2e_pkg: word types, fixed-point constants and the CORDIC arctangent table
// for the quaternion to Euler angle converter. No dependencies.
package q2e_pkg;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               gimbal_locked;
  } out_word_t;

  localparam int ARG_W  = 37;   // CORDIC x/y datapath, Q30 plus growth
  localparam int ANG_W  = 29;   // Q24 angle accumulator
  localparam int SQRT_N = 31;   // root bits, one per stage

  localparam logic signed [ANG_W-1:0] ANG_PI      = 29'sd52707179;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 29'sd26353589;
  localparam logic signed [17:0]      HALF_PI_Q12 = 18'sd6434;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ANG_W-1:0] atan_q24(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 29'sd13176795;
      1:  v = 29'sd7778716;
      2:  v = 29'sd4110060;
      3:  v = 29'sd2086331;
      4:  v = 29'sd1047214;
      5:  v = 29'sd524117;
      6:  v = 29'sd262123;
      7:  v = 29'sd131069;
      8:  v = 29'sd65536;
      9:  v = 29'sd32768;
      10: v = 29'sd16384;
      11: v = 29'sd8192;
      12: v = 29'sd4096;
      13: v = 29'sd2048;
      14: v = 29'sd1024;
      15: v = 29'sd512;
      16: v = 29'sd256;
      17: v = 29'sd128;
      18: v = 29'sd64;
      19: v = 29'sd32;
      20: v = 29'sd16;
      21: v = 29'sd8;
      22: v = 29'sd4;
      23: v = 29'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q24 -> Q12, round half up, saturate to 16 bits
  function automatic logic signed [15:0] to_q12(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    logic signed [ANG_W-1:0] r;
    logic signed [15:0]      q;
    t = a + 29'sd2048;
    r = t >>> 12;
    if (r > 29'sd32767) begin
      q = 16'sh7fff;
    end else if (r < -29'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage

// ===== src/q2e_isqrt.sv =====
// q2e_isqrt: pipelined floor square root of a 61-bit value, one root bit per
// stage, SQRT_N stages. Uses q2e_pkg.
module q2e_isqrt (
  input  logic        clk,
  input  logic [60:0] n_in,
  output logic [30:0] root
);

  localparam int N = q2e_pkg::SQRT_N;

  logic [60:0] rem_r [N];
  logic [61:0] res_r [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [60:0] rem_in;
      logic [61:0] res_in;
      logic [61:0] bitv;
      logic [61:0] trial;
      logic [60:0] rem_nxt;
      logic [61:0] res_nxt;

      if (k == 0) begin : g_first
        assign rem_in = n_in;
        assign res_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign res_in = res_r[k-1];
      end

      assign bitv  = 62'(1) << (60 - 2 * k);
      assign trial = res_in + bitv;

      always_comb begin
        if ({1'b0, rem_in} >= trial) begin
          rem_nxt = rem_in - trial[60:0];
          res_nxt = (res_in >> 1) + bitv;
        end else begin
          rem_nxt = rem_in;
          res_nxt = res_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
      end
    end
  endgenerate

  assign root = res_r[N-1][30:0];

endmodule

// ===== src/q2e_cordic.sv =====
// q2e_cordic: vectoring-mode CORDIC atan2, one register per iteration plus a
// quadrant prestage. Uses q2e_pkg.
module q2e_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                clk,
  input  logic signed [q2e_pkg::ARG_W-1:0]    y_in,
  input  logic signed [q2e_pkg::ARG_W-1:0]    x_in,
  output logic signed [q2e_pkg::ANG_W-1:0]    angle
);

  localparam int AW = q2e_pkg::ARG_W;
  localparam int ZW = q2e_pkg::ANG_W;

  logic signed [AW-1:0] x_r    [STAGES+1];
  logic signed [AW-1:0] y_r    [STAGES+1];
  logic signed [ZW-1:0] z_r    [STAGES+1];
  logic                 zero_r [STAGES+1];

  // left half-plane: rotate by +-pi first
  always_ff @(posedge clk) begin
    zero_r[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      x_r[0] <= -x_in;
      y_r[0] <= -y_in;
      z_r[0] <= (y_in >= 0) ? q2e_pkg::ANG_PI : -q2e_pkg::ANG_PI;
    end else begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      z_r[0] <= '0;
    end
  end

  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_iter
      logic signed [AW-1:0] dx;
      logic signed [AW-1:0] dy;
      assign dx = y_r[i] >>> i;
      assign dy = x_r[i] >>> i;
      always_ff @(posedge clk) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + q2e_pkg::atan_q24(i);
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - q2e_pkg::atan_q24(i);
        end
      end
    end
  endgenerate

  assign angle = zero_r[STAGES] ? '0 : z_r[STAGES];

endmodule

// ===== src/quaternion_to_euler.sv =====
// quaternion_to_euler: top level, products and atan2 arguments, pitch root,
// four parallel CORDIC pipes and the gimbal-lock select. Uses q2e_pkg,
// q2e_isqrt and q2e_cordic.
//
//  channel  ports                         handshake
//  input    start, busy, in_word          word taken when start && !busy
//  result   out_strobe, out_word          one-cycle strobe, no backpressure
//  config   cfg_valid, cfg_ready, cfg_data  written when valid && ready
//
// One word per cycle; each word passes through the 31 stage square root and
// then the CORDIC iterations. busy stays low: the pipeline never stalls
// since results cannot be held off. rst_n clears the valid line and
// lock_margin; payload registers are not reset.
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  q2e_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output q2e_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_data
);

  localparam int AW  = q2e_pkg::ARG_W;
  localparam int ZW  = q2e_pkg::ANG_W;
  localparam int SQ  = q2e_pkg::SQRT_N;
  localparam int CL  = CORDIC_STAGES + 1;
  localparam int VL  = 4 + SQ + CL + 1;   // valid line up to F1
  localparam int LAT = VL + 1;

  typedef struct packed {
    logic signed [33:0] yaw_y;
    logic signed [33:0] yaw_x;
    logic signed [33:0] roll_y;
    logic signed [33:0] roll_x;
    logic signed [33:0] lock_y;
    logic signed [33:0] lock_x;
    logic signed [31:0] s;
  } args_t;

  logic [9:0]    lock_margin_r;
  logic [VL-1:0] vld_r;
  logic          accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_margin_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      lock_margin_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VL-2:0], accept};
    end
  end

  // S1: component products, Q2.30
  logic signed [31:0] pxx_r, pyy_r, pzz_r, pww_r, pwy_r, pxz_r, pxy_r, pwz_r, pwx_r, pyz_r;
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = $signed(in_word.quat_x);
  assign qy = $signed(in_word.quat_y);
  assign qz = $signed(in_word.quat_z);
  assign qw = $signed(in_word.quat_w);

  always_ff @(posedge clk) begin
    pxx_r <= qx * qx;
    pyy_r <= qy * qy;
    pzz_r <= qz * qz;
    pww_r <= qw * qw;
    pwy_r <= qw * qy;
    pxz_r <= qx * qz;
    pxy_r <= qx * qy;
    pwz_r <= qw * qz;
    pwx_r <= qw * qx;
    pyz_r <= qy * qz;
  end

  // S2: atan2 arguments, clamped pitch sine
  logic signed [33:0] s_raw;
  logic signed [31:0] s_cl;
  logic [30:0]        s_mag;
  args_t              a2_nxt, a2_r;
  logic [30:0]        s_mag_r;

  assign s_raw = (34'(pwy_r) - 34'(pxz_r)) <<< 1;

  always_comb begin
    if (s_raw > 34'sd1073741824) begin
      s_cl = 32'sd1073741824;
    end else if (s_raw < -34'sd1073741824) begin
      s_cl = -32'sd1073741824;
    end else begin
      s_cl = s_raw[31:0];
    end
    s_mag         = s_cl[31] ? 31'(-s_cl) : s_cl[30:0];
    a2_nxt.yaw_y  = (34'(pxy_r) + 34'(pwz_r)) <<< 1;
    a2_nxt.yaw_x  = 34'(pxx_r) - 34'(pyy_r) - 34'(pzz_r) + 34'(pww_r);
    a2_nxt.roll_y = (34'(pwx_r) + 34'(pyz_r)) <<< 1;
    a2_nxt.roll_x = 34'(pww_r) - 34'(pxx_r) - 34'(pyy_r) + 34'(pzz_r);
    a2_nxt.lock_y = (34'(pyz_r) - 34'(pwx_r)) <<< 1;
    a2_nxt.lock_x = (34'(pxz_r) + 34'(pwy_r)) <<< 1;
    a2_nxt.s      = s_cl;
  end

  always_ff @(posedge clk) begin
    a2_r    <= a2_nxt;
    s_mag_r <= s_mag;
  end

  // S3: s squared; S4: 1 - s^2 in Q60
  logic [61:0] sq_r;
  logic [60:0] n_r;
  args_t       a3_r, a4_r;

  always_ff @(posedge clk) begin
    sq_r <= 62'(s_mag_r) * 62'(s_mag_r);
    a3_r <= a2_r;
    n_r  <= 61'((62'(1) << 60) - sq_r);
    a4_r <= a3_r;
  end

  // root pipe, arguments ride alongside
  logic [30:0] root;
  args_t       ad_r [SQ];

  q2e_isqrt u_isqrt (
    .clk  (clk),
    .n_in (n_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    ad_r[0] <= a4_r;
    for (int j = 1; j < SQ; j++) begin
      ad_r[j] <= ad_r[j-1];
    end
  end

  // four atan2 pipes in parallel
  logic signed [ZW-1:0] zp, zy, zr, zl;
  args_t                ac;
  assign ac = ad_r[SQ-1];

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk(clk), .y_in(AW'(ac.s)), .x_in(AW'({1'b0, root})), .angle(zp));
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk(clk), .y_in(AW'(ac.yaw_y)), .x_in(AW'(ac.yaw_x)), .angle(zy));
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk(clk), .y_in(AW'(ac.roll_y)), .x_in(AW'(ac.roll_x)), .angle(zr));
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lock (
    .clk(clk), .y_in(AW'(ac.lock_y)), .x_in(AW'(ac.lock_x)), .angle(zl));

  // pitch sideband: zero root and sign of s
  logic czero_r [CL];
  logic spos_r  [CL];

  always_ff @(posedge clk) begin
    czero_r[0] <= (root == '0);
    spos_r[0]  <= (ac.s > 0);
    for (int j = 1; j < CL; j++) begin
      czero_r[j] <= czero_r[j-1];
      spos_r[j]  <= spos_r[j-1];
    end
  end

  // F1: round all angles
  logic signed [ZW-1:0] pitch_a, yawl_a;
  logic signed [15:0]   pitch_q_r, roll_q_r, yawn_q_r, yawl_q_r;

  always_comb begin
    if (czero_r[CL-1]) begin
      pitch_a = spos_r[CL-1] ? q2e_pkg::ANG_HALF_PI : -q2e_pkg::ANG_HALF_PI;
    end else begin
      pitch_a = zp;
    end
    // rounded pitch negative exactly when the Q24 value is below -2048
    yawl_a = (pitch_a < -29'sd2048) ? zl - q2e_pkg::ANG_PI : zl;
  end

  always_ff @(posedge clk) begin
    pitch_q_r <= q2e_pkg::to_q12(pitch_a);
    roll_q_r  <= q2e_pkg::to_q12(zr);
    yawn_q_r  <= q2e_pkg::to_q12(zy);
    yawl_q_r  <= q2e_pkg::to_q12(yawl_a);
  end

  // F2: lock decision and output word
  logic signed [17:0] p_abs, lock_dist;
  logic               locked;
  logic               out_strobe_r;
  q2e_pkg::out_word_t out_word_r;

  always_comb begin
    p_abs     = pitch_q_r[15] ? -18'(pitch_q_r) : 18'(pitch_q_r);
    lock_dist = q2e_pkg::HALF_PI_Q12 - p_abs;
    locked    = lock_dist <= $signed({8'd0, lock_margin_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[VL-1];
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.pitch_angle   <= pitch_q_r;
    out_word_r.roll_angle    <= locked ? 16'sd0 : roll_q_r;
    out_word_r.yaw_angle     <= locked ? yawl_q_r : yawn_q_r;
    out_word_r.gimbal_locked <= locked;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("accepted word did not come out after pipeline latency");

  a_lock_roll : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.gimbal_locked) |-> (out_word.roll_angle == 16'sd0))
    else $error("roll not zero in gimbal lock");

  a_lock_pitch : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.gimbal_locked) |->
      (out_word.pitch_angle >= 16'sd5411 || out_word.pitch_angle <= -16'sd5411))
    else $error("gimbal lock flagged with pitch far from half pi");

  a_no_ghost : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(vld_r[VL-1]))
    else $error("result strobe without a word in flight");

endmodule
